// ----- hdl/per_cpu_page_free_list_allocator_core_defines.svh -----
// Assertion macros shared by the page allocator RTL.
// Depends on nothing; included by the top level only.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pcpa_pkg.sv -----
// Shared types and constants of the per-CPU page allocator.
// Depends on nothing; imported by the top level.
package pcpa_pkg;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Register word index (bit 2 of the byte address).
	localparam logic REG_KERNEL_END = 1'b0;
	localparam logic REG_PHYS_TOP   = 1'b1;

	localparam logic [31:0] KERNEL_END_RST = 32'h8000_0000;
	localparam logic [31:0] PHYS_TOP_RST   = 32'h8800_0000;

	typedef enum logic [1:0] {
		STAT_ALLOCATED = 2'd0,
		STAT_FREED     = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_FINISH
	} fsm_t;

endpackage

// ----- hdl/pcpa_link_ram.sv -----
// Next-link memory of the page allocator: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read enable.
module pcpa_link_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 16,
	parameter int AW    = 15
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/per_cpu_page_free_list_allocator_core.sv -----
// Top level of the per-CPU page allocator: request control, list heads, config registers.
// Depends on pcpa_pkg, pcpa_link_ram and the assertion macro header.
`include "per_cpu_page_free_list_allocator_core_defines.svh"

// Per-CPU free-list page allocator. A request is taken when start is high and
// busy is low; kind 0 allocates a page for the given CPU, kind 1 frees the page
// at address. Exactly one result follows every request: done is high for one
// cycle, with page_address and status valid in that cycle. The receiver
// cannot stall, so the result must be captured while done is high. busy is
// high through the check and finish stages after acceptance and low again in
// the cycle that shows the result, so a new request may be taken in that
// cycle. The check stage forms the page base and the range checks and issues
// the read of the next-link memory, and the finish stage takes the registered
// link, moves the list head and writes the link of a freed page. Each CPU
// keeps a last-in first-out list; an allocation from an empty list takes from
// the lowest-numbered non-empty list, and reports no free page when all are
// empty. Rejected frees (misaligned, below kernel_end, at or above phys_top,
// outside the store, or from an absent CPU) report status 3 and change
// nothing. Freeing a page twice is not detected. The link memory needs no
// clearing after reset, as a link is only read after it has been written.
// PAGE_BYTES must be a power of two. kernel_end and phys_top are written over
// the APB port at byte addresses 0 and 4; the user must write them only while
// no request is in progress, as the block itself does not enforce this.
module per_cpu_page_free_list_allocator_core
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [2:0]  cpu,
	input  logic [31:0] address,
	output logic        done,
	output logic [31:0] page_address,
	output logic [1:0]  status
);

	localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PB_W   = $clog2(PAGE_BYTES);
	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int LINK_W = SLOT_W + 1;
	localparam logic [32:0] PB_MASK   = 33'(PAGE_BYTES - 1);
	localparam logic [32:0] PAGES_LIM = 33'(MAX_PAGES);

	// Configuration registers.
	logic [31:0] kernel_end_q;
	logic [31:0] phys_top_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_end_q <= KERNEL_END_RST;
			phys_top_q   <= PHYS_TOP_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_KERNEL_END) begin
				kernel_end_q <= pwdata;
			end else begin
				phys_top_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_KERNEL_END) ? kernel_end_q : phys_top_q;

	// Request control.
	fsm_t state_q, state_d;
	logic accept;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_CHECK;
				end
			end
			FSM_CHECK:  state_d = FSM_FINISH;
			FSM_FINISH: state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// Accepted request.
	logic        kind_q;
	logic [2:0]  cpu_q;
	logic [31:0] addr_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			cpu_q  <= cpu;
			addr_q <= address;
		end
	end

	// List heads: a valid bit and a slot per CPU.
	logic [NUM_CPUS-1:0] heads_vld_q;
	logic [SLOT_W-1:0]   heads_slot_q [NUM_CPUS];

	// Check stage: page base, range checks and choice of the list to use.
	logic             cpu_ok;
	logic [CPU_W-1:0] cpu_idx;
	logic [32:0]      base_w;
	logic             bad_w;
	logic [CPU_W-1:0] first_idx;
	logic [CPU_W-1:0] head_idx_w;
	logic             hit_w;

	assign cpu_ok  = (32'(cpu_q) < NUM_CPUS);
	assign cpu_idx = CPU_W'(cpu_q);
	assign base_w  = ({1'b0, kernel_end_q} + PB_MASK) & ~PB_MASK;

	assign bad_w = (|addr_q[PB_W-1:0]) || (addr_q < kernel_end_q)
		|| (addr_q >= phys_top_q) || !cpu_ok || ({1'b0, addr_q} < base_w);

	// Lowest-numbered non-empty list.
	always_comb begin
		first_idx = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (heads_vld_q[i]) begin
				first_idx = CPU_W'(i);
			end
		end
	end

	always_comb begin
		if (kind_q == KIND_FREE) begin
			head_idx_w = cpu_idx;
			hit_w      = 1'b0;
		end else if (cpu_ok && heads_vld_q[cpu_idx]) begin
			head_idx_w = cpu_idx;
			hit_w      = 1'b1;
		end else begin
			head_idx_w = first_idx;
			hit_w      = |heads_vld_q;
		end
	end

	logic [32:0]      base_s1;
	logic             bad_s1;
	logic             hit_s1;
	logic [CPU_W-1:0] head_idx_s1;
	logic [LINK_W-1:0] head_s1;

	always_ff @(posedge clk) begin
		if (state_q == FSM_CHECK) begin
			base_s1     <= base_w;
			bad_s1      <= bad_w;
			hit_s1      <= hit_w;
			head_idx_s1 <= head_idx_w;
			head_s1     <= {heads_vld_q[head_idx_w], heads_slot_q[head_idx_w]};
		end
	end

	// Next-link memory. The read for a pop is issued in the check stage.
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic              ram_re;
	logic [LINK_W-1:0] ram_rdata;

	assign ram_re = (state_q == FSM_CHECK) && (kind_q == KIND_ALLOC) && hit_w;

	pcpa_link_ram #(
		.DEPTH (MAX_PAGES),
		.WIDTH (LINK_W),
		.AW    (SLOT_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (head_s1),
		.re    (ram_re),
		.raddr (heads_slot_q[head_idx_w]),
		.rdata (ram_rdata)
	);

	// Finish stage: slot of a freed page, head update and the result.
	logic [32:0] diff_w;
	logic [32:0] slot_wide_w;
	logic        push_w;
	logic        pop_w;
	logic [31:0] page_w;

	assign diff_w      = {1'b0, addr_q} - base_s1;
	assign slot_wide_w = diff_w >> PB_W;
	assign push_w      = (state_q == FSM_FINISH) && (kind_q == KIND_FREE)
		&& !bad_s1 && (slot_wide_w < PAGES_LIM);
	assign pop_w       = (state_q == FSM_FINISH) && (kind_q == KIND_ALLOC) && hit_s1;
	assign ram_we      = push_w;
	assign ram_waddr   = slot_wide_w[SLOT_W-1:0];
	assign page_w      = base_s1[31:0] + (32'(head_s1[SLOT_W-1:0]) << PB_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_vld_q <= '0;
		end else if (push_w) begin
			heads_vld_q[head_idx_s1] <= 1'b1;
		end else if (pop_w) begin
			heads_vld_q[head_idx_s1] <= ram_rdata[SLOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (push_w) begin
			heads_slot_q[head_idx_s1] <= slot_wide_w[SLOT_W-1:0];
		end else if (pop_w) begin
			heads_slot_q[head_idx_s1] <= ram_rdata[SLOT_W-1:0];
		end
	end

	// Result register: shown for exactly one cycle.
	logic        done_q;
	logic [31:0] page_q;
	status_t     status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == FSM_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_FINISH) begin
			if (kind_q == KIND_FREE) begin
				page_q   <= '0;
				status_q <= push_w ? STAT_FREED : STAT_BAD_FREE;
			end else if (hit_s1) begin
				page_q   <= page_w;
				status_q <= STAT_ALLOCATED;
			end else begin
				page_q   <= '0;
				status_q <= STAT_EMPTY;
			end
		end
	end

	assign done         = done_q;
	assign page_address = page_q;
	assign status       = status_q;

	// Checks on the control flow and the result encoding.
	`PCPA_ASSERT_NEXT(a_accept_to_check, clk, arst_n, accept, state_q == FSM_CHECK, "accepted request did not enter the check stage")
	`PCPA_ASSERT_NEXT(a_finish_to_done, clk, arst_n, state_q == FSM_FINISH, done && !busy, "finish stage did not produce exactly one result")
	`PCPA_ASSERT_NOW(a_page_zero, clk, arst_n, done && (status != STAT_ALLOCATED), page_address == 32'd0, "non-allocation result carries a page address")
	`PCPA_ASSERT_NOW(a_no_push_pop, clk, arst_n, push_w, !pop_w, "head pushed and popped in one cycle")

endmodule
